// ----- sv/obsm_pkg.sv -----
`timescale 1ns / 1ps
// obsm_pkg: shared types and codes of the ofdm bit-to-subcarrier mapper
// no dependencies

package obsm_pkg;

   // command codes of an input item
   localparam logic [1:0] CMD_DATA  = 2'd0;
   localparam logic [1:0] CMD_CONST = 2'd1;
   localparam logic [1:0] CMD_MAP   = 2'd2;

   // configuration register indexes
   localparam logic CSR_BITS_PER_SYMBOL = 1'b0;
   localparam logic CSR_OCCUPIED_COUNT  = 1'b1;

   localparam int BYTE_BITS = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_SEND
   } seq_state_type;

   // one step of the chunk extractor
   typedef struct packed {
      logic [7:0] chunk;
      logic [3:0] off_next;
      logic       more;
      logic [7:0] res_bits;
      logic [3:0] res_miss;
   } chunk_step_type;

endpackage

// ----- sv/obsm_ifs.sv -----
`timescale 1ns / 1ps
// obsm_req_if and obsm_rsp_if: valid/ready channels of the mapper
// no dependencies

interface obsm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [7:0]         data_byte;
   logic               last_byte;
   logic [7:0]         table_index;
   logic signed [15:0] entry_i;
   logic signed [15:0] entry_q;
   logic [5:0]         entry_bin;

   modport source (output valid, cmd, data_byte, last_byte, table_index, entry_i, entry_q,
                   entry_bin, input ready);
   modport sink (input valid, cmd, data_byte, last_byte, table_index, entry_i, entry_q,
                 entry_bin, output ready);
endinterface

interface obsm_rsp_if;
   logic               valid;
   logic               ready;
   logic               point_valid;
   logic [5:0]         bin_index;
   logic signed [15:0] point_i;
   logic signed [15:0] point_q;
   logic               packet_start;
   logic               symbol_end;
   logic               last;

   modport source (output valid, point_valid, bin_index, point_i, point_q, packet_start,
                   symbol_end, last, input ready);
   modport sink (input valid, point_valid, bin_index, point_i, point_q, packet_start,
                 symbol_end, last, output ready);
endinterface

// ----- sv/obsm_chunk_unit.sv -----
`timescale 1ns / 1ps
// obsm_chunk_unit: shared shift/mask unit, cuts one chunk off the current byte
// depends on obsm_pkg

module obsm_chunk_unit (
   input  logic [7:0]              byte_val,
   input  logic [3:0]              offset,
   input  logic [3:0]              nbits,
   input  logic                    join_res,
   input  logic [7:0]              res_bits,
   input  logic [3:0]              res_miss,
   output obsm_pkg::chunk_step_type step
);
   import obsm_pkg::*;

   logic [2:0]  miss;
   logic [3:0]  shift;
   logic [7:0]  miss_mask;
   logic [7:0]  n_mask;
   logic [15:0] joined;
   logic [3:0]  off_next;
   logic [3:0]  remain;
   logic [7:0]  rem_mask;

   always_comb begin
      miss      = (res_miss > 4'd7) ? 3'd7 : res_miss[2:0];
      shift     = (nbits > {1'b0, miss}) ? nbits - {1'b0, miss} : 4'd0;
      miss_mask = 8'((9'd1 << miss) - 9'd1);
      n_mask    = 8'((9'd1 << nbits) - 9'd1);
      joined    = {8'd0, res_bits} | ({8'd0, byte_val & miss_mask} << shift);

      if (join_res) begin
         step.chunk = joined[7:0];
         off_next   = {1'b0, miss};
      end else begin
         step.chunk = (byte_val >> offset) & n_mask;
         off_next   = offset + nbits;
      end

      remain        = 4'(BYTE_BITS) - off_next;
      rem_mask      = 8'((9'd1 << remain) - 9'd1);
      step.off_next = off_next;
      step.more     = (remain >= nbits);
      step.res_bits = (byte_val >> off_next) & rem_mask;
      step.res_miss = (remain == 4'd0) ? 4'd0 : nbits - remain;
   end

endmodule

// ----- sv/obsm_tables.sv -----
`timescale 1ns / 1ps
// obsm_tables: constellation and carrier-map memories with registered reads
// depends on obsm_pkg

module obsm_tables #(
   parameter int FFT_LEN      = 64,
   parameter int MAX_POINTS   = 256,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               const_we,
   input  logic               map_we,
   input  logic [7:0]         wr_index,
   input  logic [15:0]        wr_i,
   input  logic [15:0]        wr_q,
   input  logic [5:0]         wr_bin,
   input  logic               rd_en,
   input  logic [7:0]         rd_chunk,
   input  logic [6:0]         rd_pos,
   output logic [15:0]        rd_i,
   output logic [15:0]        rd_q,
   output logic [5:0]         rd_bin
);
   import obsm_pkg::*;

   localparam int SW = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
   localparam int CW = $clog2(MAX_POINTS);
   localparam int MW = $clog2(FFT_LEN);

   logic [SW-1:0] const_i_mem [MAX_POINTS];
   logic [SW-1:0] const_q_mem [MAX_POINTS];
   logic [5:0]    map_mem     [FFT_LEN];

   logic [SW-1:0] rd_i_ff;
   logic [SW-1:0] rd_q_ff;
   logic [5:0]    rd_bin_ff;
   logic          rd_zero_ff;

   logic [CW-1:0] const_wa;
   logic [CW-1:0] const_ra;
   logic [MW-1:0] map_wa;
   logic [MW-1:0] map_ra;
   logic [MW+7:0] map_wa_ext;
   logic [MW+6:0] map_ra_ext;
   logic          const_wr_ok;
   logic          map_wr_ok;
   logic          chunk_ok;

   always_comb begin
      map_wa_ext  = {{MW{1'b0}}, wr_index};
      map_ra_ext  = {{MW{1'b0}}, rd_pos};
      map_wa      = map_wa_ext[MW-1:0];
      map_ra      = map_ra_ext[MW-1:0];
      const_wa    = wr_index[CW-1:0];
      const_ra    = rd_chunk[CW-1:0];
      const_wr_ok = (32'(wr_index) < 32'(MAX_POINTS));
      map_wr_ok   = (32'(wr_index) < 32'(FFT_LEN));
      chunk_ok    = (32'(rd_chunk) < 32'(MAX_POINTS));
   end

   always_ff @(posedge clock) begin
      if (const_we && const_wr_ok) begin
         const_i_mem[const_wa] <= wr_i[SW-1:0];
         const_q_mem[const_wa] <= wr_q[SW-1:0];
      end
      if (map_we && map_wr_ok) begin
         map_mem[map_wa] <= wr_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_i_ff    <= const_i_mem[const_ra];
         rd_q_ff    <= const_q_mem[const_ra];
         rd_bin_ff  <= map_mem[map_ra];
         rd_zero_ff <= !chunk_ok;
      end
   end

   // chunk past the table reads as the origin
   assign rd_i   = rd_zero_ff ? 16'd0 : 16'({{16{1'b0}}, rd_i_ff});
   assign rd_q   = rd_zero_ff ? 16'd0 : 16'({{16{1'b0}}, rd_q_ff});
   assign rd_bin = rd_bin_ff;

endmodule

// ----- sv/ofdm_bit_to_subcarrier_mapper_unit.sv -----
`timescale 1ns / 1ps
// ofdm_bit_to_subcarrier_mapper_unit: byte-to-constellation-point mapper, top level
// depends on obsm_pkg, obsm_ifs, obsm_chunk_unit, obsm_tables
// the first point of a data byte is read from the tables in the issue state and then
//   offered in the send state; one point per cycle while the point sink is ready,
//   through the shared chunk unit and the table read port; no new byte or table write
//   is taken until the last point of the current byte is taken
// reset: synchronous active high, clears sequencer, residual and carrier position,
//   loads bits_per_symbol 2 and occupied_count 48; table contents are kept

module ofdm_bit_to_subcarrier_mapper_unit #(
   parameter int FFT_LEN      = 64,
   parameter int MAX_POINTS   = 256,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   obsm_req_if.sink   req_ch,
   obsm_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);
   import obsm_pkg::*;

   // the occupied count never exceeds the 7-bit register or the fft length
   localparam int OCC_CAP = (FFT_LEN < 127) ? FFT_LEN : 127;

   // configuration
   logic [3:0] bps_ff;
   logic [6:0] occ_ff;
   logic [3:0] nbits;
   logic [6:0] occ_eff;

   // sequencer
   seq_state_type state_ff, state_in;
   logic          issue;
   logic          accept;
   logic          data_accept;

   // per-byte working state
   logic [7:0] byte_ff;
   logic       lastb_ff;
   logic [3:0] off_ff;
   logic       join_ff;
   logic       more_ff;

   // state kept across bytes
   logic [7:0] res_bits_ff;
   logic [3:0] res_miss_ff;
   logic [6:0] pos_ff;
   logic       start_ff;

   // flags of the item in the output register
   logic start_out_ff;
   logic end_out_ff;
   logic last_out_ff;

   chunk_step_type step;
   logic [7:0]     pos_inc;
   logic           sym_close;
   logic [15:0]    rd_i;
   logic [15:0]    rd_q;
   logic [5:0]     rd_bin;

   // out-of-range register values are pulled into range
   always_comb begin
      if (bps_ff == 4'd0) begin
         nbits = 4'd1;
      end else if (bps_ff > 4'(BYTE_BITS)) begin
         nbits = 4'(BYTE_BITS);
      end else begin
         nbits = bps_ff;
      end
      if (occ_ff == 7'd0) begin
         occ_eff = 7'd1;
      end else if (occ_ff > 7'(OCC_CAP)) begin
         occ_eff = 7'(OCC_CAP);
      end else begin
         occ_eff = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff <= 4'd2;
         occ_ff <= 7'd48;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BITS_PER_SYMBOL: bps_ff <= csr_wdata[3:0];
            CSR_OCCUPIED_COUNT:  occ_ff <= csr_wdata;
            default:             bps_ff <= bps_ff;
         endcase
      end
   end

   // sequencer: idle takes items, issue does the first table read,
   // send holds a point and issues the next read when it is taken
   always_comb begin
      state_in      = state_ff;
      issue         = 1'b0;
      req_ch.ready  = 1'b0;
      rsp_ch.valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no item is taken while reset is high
            req_ch.ready = !reset;
            if (req_ch.valid && (req_ch.cmd == CMD_DATA)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            issue    = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               if (more_ff) begin
                  issue = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept      = req_ch.valid && req_ch.ready;
   assign data_accept = accept && (req_ch.cmd == CMD_DATA);

   obsm_chunk_unit u_chunk (
      .byte_val (byte_ff),
      .offset   (off_ff),
      .nbits    (nbits),
      .join_res (join_ff),
      .res_bits (res_bits_ff),
      .res_miss (res_miss_ff),
      .step     (step)
   );

   obsm_tables #(
      .FFT_LEN      (FFT_LEN),
      .MAX_POINTS   (MAX_POINTS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_tables (
      .clock    (clock),
      .const_we (accept && (req_ch.cmd == CMD_CONST)),
      .map_we   (accept && (req_ch.cmd == CMD_MAP)),
      .wr_index (req_ch.table_index),
      .wr_i     (req_ch.entry_i),
      .wr_q     (req_ch.entry_q),
      .wr_bin   (req_ch.entry_bin),
      .rd_en    (issue),
      .rd_chunk (step.chunk),
      .rd_pos   (pos_ff),
      .rd_i     (rd_i),
      .rd_q     (rd_q),
      .rd_bin   (rd_bin)
   );

   assign pos_inc   = {1'b0, pos_ff} + 8'd1;
   assign sym_close = (pos_inc >= {1'b0, occ_eff});

   // byte capture; a pending residual makes the first chunk a joined one
   always_ff @(posedge clock) begin
      if (data_accept) begin
         byte_ff  <= req_ch.data_byte;
         lastb_ff <= req_ch.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= 4'd0;
         join_ff      <= 1'b0;
         more_ff      <= 1'b0;
         res_bits_ff  <= 8'd0;
         res_miss_ff  <= 4'd0;
         pos_ff       <= 7'd0;
         start_ff     <= 1'b1;
         start_out_ff <= 1'b0;
         end_out_ff   <= 1'b0;
         last_out_ff  <= 1'b0;
      end else if (data_accept) begin
         off_ff  <= 4'd0;
         join_ff <= (res_miss_ff != 4'd0);
      end else if (issue) begin
         off_ff       <= step.off_next;
         join_ff      <= 1'b0;
         more_ff      <= step.more;
         start_out_ff <= start_ff;
         last_out_ff  <= !step.more;
         end_out_ff   <= sym_close || (!step.more && lastb_ff);
         if (!step.more && lastb_ff) begin
            // packet end: partial chunk dropped, symbol closed, next byte opens a packet
            res_bits_ff <= 8'd0;
            res_miss_ff <= 4'd0;
            pos_ff      <= 7'd0;
            start_ff    <= 1'b1;
         end else begin
            start_ff <= 1'b0;
            pos_ff   <= sym_close ? 7'd0 : pos_inc[6:0];
            if (!step.more) begin
               res_bits_ff <= step.res_bits;
               res_miss_ff <= step.res_miss;
            end
         end
      end
   end

   // every data byte yields at least one point, so the bare end marker never occurs
   assign rsp_ch.point_valid  = 1'b1;
   assign rsp_ch.bin_index    = rd_bin;
   assign rsp_ch.point_i      = rd_i;
   assign rsp_ch.point_q      = rd_q;
   assign rsp_ch.packet_start = start_out_ff;
   assign rsp_ch.symbol_end   = end_out_ff;
   assign rsp_ch.last         = last_out_ff;

endmodule

// ----- dv/ofdm_bit_to_subcarrier_mapper_unit_tb.sv -----
`timescale 1ns / 1ps
// ofdm_bit_to_subcarrier_mapper_unit_tb: self-checking bench for the bit-to-subcarrier mapper
// depends on obsm_pkg, obsm_ifs and the mapper rtl; drives bytes and table writes, checks
// every mapped point against a local model of chunking, table lookup and symbol framing

module ofdm_bit_to_subcarrier_mapper_unit_tb;
   import obsm_pkg::*;

   // reserved command code, the mapper drops it
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CONST_DEPTH = 256;
   localparam int FFT_BINS    = 64;
   // longest stretch with no handshake on either side before the run is called hung
   localparam int STALL_LIMIT = 3000;
   // cycles granted to an in-flight byte or table write before a register write
   localparam int QUIET_CYCLES = 12;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         data_byte;
      logic               last_byte;
      logic [7:0]         table_index;
      logic signed [15:0] entry_i;
      logic signed [15:0] entry_q;
      logic [5:0]         entry_bin;
   } req_item_type;

   typedef struct packed {
      logic               point_valid;
      logic [5:0]         bin_index;
      logic signed [15:0] point_i;
      logic signed [15:0] point_q;
      logic               packet_start;
      logic               symbol_end;
      logic               last;
   } mapped_point_type;

   // one line of the directed sequence: an item or a register write
   typedef struct {
      bit               is_csr;
      req_item_type     item;
      bit               typed;
      mapped_point_type first;
      logic             csr_idx;
      logic [6:0]       csr_val;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_we    = 1'b0;
   logic       csr_index = 1'b0;
   logic [6:0] csr_wdata = '0;

   obsm_req_if req_if ();
   obsm_rsp_if rsp_if ();

   ofdm_bit_to_subcarrier_mapper_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // local copy of the mapper state
   logic [3:0]  cfg_bits = 4'd2;
   logic [6:0]  cfg_occ  = 7'd48;
   int unsigned res_bits    = 0;
   int unsigned res_miss    = 0;
   int unsigned carrier_pos = 0;
   bit          start_pend  = 1'b1;
   logic [31:0] const_tbl [CONST_DEPTH];
   logic [5:0]  map_tbl [FFT_BINS];

   mapped_point_type expected_points[$];
   stim_row_type     directed_rows[$];
   int               mismatches = 0;
   bit               send_idle_on = 1'b1;
   bit               rsp_idle_on  = 1'b1;
   int               quiet_cycles = 0;

   // look up one chunk, place it on the next carrier and advance the symbol framing
   function automatic mapped_point_type next_point(int unsigned chunk);
      mapped_point_type p;
      int unsigned      occ;
      occ = (cfg_occ == 0) ? 1 : (cfg_occ > FFT_BINS) ? FFT_BINS : cfg_occ;
      p.point_valid  = 1'b1;
      p.bin_index    = map_tbl[carrier_pos[5:0]];
      p.point_i      = const_tbl[chunk[7:0]][15:0];
      p.point_q      = const_tbl[chunk[7:0]][31:16];
      p.packet_start = start_pend;
      start_pend     = 1'b0;
      carrier_pos++;
      // a position left past a shrunken symbol also closes it here
      p.symbol_end = (carrier_pos >= occ);
      if (p.symbol_end) carrier_pos = 0;
      p.last = 1'b0;
      return p;
   endfunction

   // apply one accepted item to the local state and queue the points it yields
   function automatic void map_item(req_item_type it, bit typed, mapped_point_type first);
      mapped_point_type pts [BYTE_BITS];
      int          count;
      int unsigned n, mask, off, miss, shift, chunk, extra;
      count = 0;
      case (it.cmd)
         CMD_CONST: const_tbl[it.table_index] = {it.entry_q, it.entry_i};
         CMD_MAP: if (it.table_index < FFT_BINS) map_tbl[it.table_index[5:0]] = it.entry_bin;
         CMD_DATA: begin
            n    = (cfg_bits == 0) ? 1 : (cfg_bits > BYTE_BITS) ? BYTE_BITS : cfg_bits;
            mask = (1 << n) - 1;
            off  = 0;
            // finish a chunk left open by the previous byte
            if (res_miss > 0) begin
               miss  = (res_miss > 7) ? 7 : res_miss;
               shift = (n > miss) ? n - miss : 0;
               chunk = (res_bits | ((it.data_byte & ((1 << miss) - 1)) << shift)) & 8'hFF;
               pts[count++] = next_point(chunk);
               off      = miss;
               res_miss = 0;
               res_bits = 0;
            end
            while (off < BYTE_BITS) begin
               if (BYTE_BITS - off >= n) begin
                  pts[count++] = next_point((it.data_byte >> off) & mask);
                  off += n;
               end else begin
                  extra    = BYTE_BITS - off;
                  res_bits = (it.data_byte >> off) & ((1 << extra) - 1);
                  res_miss = n - extra;
                  off      = BYTE_BITS;
               end
            end
            // packet end drops a partial chunk and closes the open symbol
            if (it.last_byte) begin
               res_bits = 0;
               res_miss = 0;
               pts[count - 1].symbol_end = 1'b1;
               carrier_pos = 0;
               start_pend  = 1'b1;
            end
            pts[count - 1].last = 1'b1;
            if (typed) pts[0] = first;
            for (int k = 0; k < count; k++) expected_points.push_back(pts[k]);
         end
         default: ;
      endcase
   endfunction

   function automatic void add_item(logic [1:0] cmd, logic [7:0] data, logic last_b,
                                    logic [7:0] idx, logic [15:0] ei, logic [15:0] eq,
                                    logic [5:0] bin, bit typed = 1'b0,
                                    mapped_point_type first = '0);
      stim_row_type r;
      r.is_csr  = 1'b0;
      r.item    = '{cmd, data, last_b, idx, ei, eq, bin};
      r.typed   = typed;
      r.first   = first;
      r.csr_idx = 1'b0;
      r.csr_val = '0;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_csr(logic idx, logic [6:0] val);
      stim_row_type r;
      r.is_csr  = 1'b1;
      r.item    = '0;
      r.typed   = 1'b0;
      r.first   = '0;
      r.csr_idx = idx;
      r.csr_val = val;
      directed_rows.push_back(r);
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want_v,
                                       logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endfunction

   // offer one item after a random gap and hold it until the mapper takes it
   task automatic send_item(req_item_type it, bit typed, mapped_point_type first);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.cmd         <= it.cmd;
      req_if.data_byte   <= it.data_byte;
      req_if.last_byte   <= it.last_byte;
      req_if.table_index <= it.table_index;
      req_if.entry_i     <= it.entry_i;
      req_if.entry_q     <= it.entry_q;
      req_if.entry_bin   <= it.entry_bin;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      map_item(it, typed, first);
   endtask

   // drain all points, then let a trailing table write or dropped item finish
   task automatic wait_mapper_idle();
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [6:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_BITS_PER_SYMBOL) cfg_bits = val[3:0];
      else cfg_occ = val;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // point sink: random back-pressure, every point checked against the oldest expectation
   initial begin
      int               stall;
      mapped_point_type got;
      mapped_point_type want;
      rsp_if.ready = 1'b0;
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got.point_valid  = rsp_if.point_valid;
         got.bin_index    = rsp_if.bin_index;
         got.point_i      = rsp_if.point_i;
         got.point_q      = rsp_if.point_q;
         got.packet_start = rsp_if.packet_start;
         got.symbol_end   = rsp_if.symbol_end;
         got.last         = rsp_if.last;
         if (expected_points.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected point, expected none, actual bin %0d i %0d q %0d",
                     $time, got.bin_index, got.point_i, got.point_q);
         end else begin
            want = expected_points.pop_front();
            check_field("point_valid", want.point_valid, got.point_valid);
            check_field("bin_index", want.bin_index, got.bin_index);
            check_field("point_i", want.point_i, got.point_i);
            check_field("point_q", want.point_q, got.point_q);
            check_field("packet_start", want.packet_start, got.packet_start);
            check_field("symbol_end", want.symbol_end, got.symbol_end);
            check_field("last", want.last, got.last);
         end
      end
   end

   // hang detector: no handshake on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("ofdm_bit_to_subcarrier_mapper_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_item_type it;
      logic [63:0]  rnd;
      int           roll;
      logic [6:0]   bps_val;
      logic [6:0]   occ_val;

      req_if.valid       = 1'b0;
      req_if.cmd         = CMD_DATA;
      req_if.data_byte   = '0;
      req_if.last_byte   = 1'b0;
      req_if.table_index = '0;
      req_if.entry_i     = '0;
      req_if.entry_q     = '0;
      req_if.entry_bin   = '0;

      // directed sequence, registers still at reset values for the first bytes
      add_item(CMD_CONST, 8'h00, 1'b0, 8'd0, 16'h7FFF, 16'h8000, 6'd0);
      add_item(CMD_CONST, 8'h00, 1'b0, 8'd255, 16'h8000, 16'h7FFF, 6'd0);
      add_item(CMD_MAP, 8'h00, 1'b0, 8'd0, 16'h0000, 16'h0000, 6'd63);
      // map index past the carrier table is dropped
      add_item(CMD_MAP, 8'h00, 1'b0, 8'd255, 16'h0000, 16'h0000, 6'd0);
      // reserved command with every field at ones
      add_item(CMD_UNUSED, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);
      // two bits per point, four chunks of zero, first one opens the packet
      add_item(CMD_DATA, 8'h00, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0, 1'b1,
               '{1'b1, 6'd63, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b0});
      add_item(CMD_DATA, 8'hFF, 1'b1, 8'h00, 16'h0, 16'h0, 6'd0);
      // whole byte per point
      add_csr(CSR_BITS_PER_SYMBOL, 7'd8);
      add_item(CMD_DATA, 8'hFF, 1'b1, 8'h00, 16'h0, 16'h0, 6'd0, 1'b1,
               '{1'b1, 6'd63, 16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b1});
      add_item(CMD_DATA, 8'h00, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0, 1'b1,
               '{1'b1, 6'd63, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b1});
      // shrink the symbol under an open position
      add_csr(CSR_OCCUPIED_COUNT, 7'd1);
      add_item(CMD_DATA, 8'h81, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      add_csr(CSR_OCCUPIED_COUNT, 7'd64);
      // three bits per point, chunks straddle byte boundaries
      add_csr(CSR_BITS_PER_SYMBOL, 7'd3);
      add_item(CMD_DATA, 8'hA5, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      add_item(CMD_DATA, 8'h3C, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      add_item(CMD_DATA, 8'h5A, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      add_item(CMD_DATA, 8'hC3, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      // zero acts as one bit; the open residual is now wider than a point
      add_csr(CSR_BITS_PER_SYMBOL, 7'd0);
      add_item(CMD_DATA, 8'h96, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      add_csr(CSR_BITS_PER_SYMBOL, 7'd5);
      add_csr(CSR_OCCUPIED_COUNT, 7'd0);
      add_item(CMD_DATA, 8'h37, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      // packet end with a partial chunk pending
      add_item(CMD_DATA, 8'hEE, 1'b1, 8'h00, 16'h0, 16'h0, 6'd0);
      // out-of-range register values clamp to eight bits and a full symbol
      add_csr(CSR_BITS_PER_SYMBOL, 7'd15);
      add_csr(CSR_OCCUPIED_COUNT, 7'd127);
      add_item(CMD_DATA, 8'h00, 1'b0, 8'h00, 16'h0, 16'h0, 6'd0);
      add_item(CMD_DATA, 8'hFF, 1'b1, 8'h00, 16'h0, 16'h0, 6'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill both tables so that no lookup ever hits an unwritten entry
      for (int k = 0; k < CONST_DEPTH; k++) begin
         it = '0;
         it.cmd         = CMD_CONST;
         it.table_index = k[7:0];
         it.entry_i     = 16'($urandom);
         it.entry_q     = 16'($urandom);
         send_item(it, 1'b0, '0);
      end
      for (int k = 0; k < FFT_BINS; k++) begin
         it = '0;
         it.cmd         = CMD_MAP;
         it.table_index = k[7:0];
         it.entry_bin   = 6'($urandom);
         send_item(it, 1'b0, '0);
      end

      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_csr) begin
            wait_mapper_idle();
            write_csr(directed_rows[r].csr_idx, directed_rows[r].csr_val);
         end else begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].first);
         end
      end

      // random phases: new register setting, then a mix of packets and table updates;
      // packets may stay open across a phase boundary on purpose
      for (int phase = 0; phase < 10; phase++) begin
         wait_mapper_idle();
         case ($urandom_range(0, 5))
            0: bps_val = 7'($urandom_range(0, 127));
            1: bps_val = 7'd1;
            2: bps_val = 7'd8;
            default: bps_val = 7'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 5))
            0: occ_val = 7'($urandom_range(0, 127));
            1: occ_val = 7'd1;
            2: occ_val = 7'd64;
            default: occ_val = 7'($urandom_range(1, 64));
         endcase
         write_csr(CSR_BITS_PER_SYMBOL, bps_val);
         write_csr(CSR_OCCUPIED_COUNT, occ_val);
         // some phases run without any idling on one or both sides
         send_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on  = ($urandom_range(0, 3) != 0);
         repeat (25) begin
            rnd  = {$urandom, $urandom};
            it   = rnd[$bits(req_item_type)-1:0];
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               it.cmd       = CMD_DATA;
               it.last_byte = ($urandom_range(0, 5) == 0);
            end else if (roll < 85) begin
               it.cmd = CMD_CONST;
            end else if (roll < 95) begin
               it.cmd         = CMD_MAP;
               it.table_index = $urandom_range(0, 1) ? 8'($urandom_range(0, 63))
                                                     : 8'($urandom_range(0, 255));
            end else begin
               it.cmd = CMD_UNUSED;
            end
            send_item(it, 1'b0, '0);
         end
      end

      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      // catch any stray point after the last expected one
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("ofdm_bit_to_subcarrier_mapper_unit verification clean");
      end else begin
         $display("ofdm_bit_to_subcarrier_mapper_unit verification failed");
      end
      $finish;
   end

endmodule
